FILE: rtl/core/ptau_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ptau_pkg: shared definitions for the point track assignment unit
// Request codes, fixed field widths and register map of the block.
// ============================================================================
package ptau_pkg;

    // Request kinds carried on the input tuser field.
    localparam logic [1:0] REQ_LOAD_PREV = 2'd0;
    localparam logic [1:0] REQ_LOAD_CUR  = 2'd1;
    localparam logic [1:0] REQ_SOLVE     = 2'd2;

    // Fixed widths of the result fields and of the distance register.
    localparam int IDX_OUT_W = 5;
    localparam int DIST_W    = 17;

    // Register map: word index taken from paddr[2].
    localparam int          APB_ADDR_W   = 3;
    localparam logic [0:0]  REG_MAX_DIST = 1'b0;
    localparam logic [16:0] MAX_DIST_RST = 17'd800;

endpackage

FILE: rtl/core/ptau_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// ptau_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module ptau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

FILE: rtl/core/point_track_assignment_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// point_track_assignment_unit: frame-to-frame point linking by Munkres
// Loads previous and current points, builds a Euclidean cost matrix and
// solves the assignment with one shared multiplier under a sequencer.
// ============================================================================
// A point load leaves the sequencer idle, so the input stream stays ready.
// A solve item keeps the block busy: building the matrix takes one integer
// square root per real cell, one bit per cycle on the shared multiplier
// (padding cells are written as zero); the row and the column reduction each
// make a minimum pass and a subtract pass, cost memory read then act; then come
// the starring, zero search, minimum and adjust sweeps, and each result with a
// real partner takes a fresh distance; any output stall holds the block too.
// Reset (rst_n, asynchronous) empties both point lists, sets max_distance to 800
// and returns the sequencer to idle; the memories need no clearing pass.
module point_track_assignment_unit
    import ptau_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata, lowest bit up: x_coord, y_coord, zero fill.
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_tdata,
    // tuser: req_type.
    input  logic [1:0]                           s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata, lowest bit up: current_index, matched_prev, zero fill.
    output logic [15:0]                          m_tdata,
    // tuser: is_matched.
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [APB_ADDR_W-1:0]                paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // Index width for a point, count width that can hold MAX_POINTS itself.
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CW    = IW + 1;
    localparam int PW    = 2 * COORD_BITS;
    // Distance width: the root of (2 * max_coord^2) << (2*FRAC_BITS).
    localparam int DW    = COORD_BITS + FRAC_BITS + 1;
    localparam int VW    = 2 * DW;
    localparam int SW    = $clog2(DW);
    localparam int CMP_W = (DW > DIST_W) ? DW : DIST_W;
    localparam int CELLS = 1 << (2 * IW);

    // Sequencer states.
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_BLD_RD   = 5'd1;
    localparam logic [4:0] S_BLD_WR   = 5'd2;
    localparam logic [4:0] S_D_RD     = 5'd3;
    localparam logic [4:0] S_D_DIF    = 5'd4;
    localparam logic [4:0] S_D_MX     = 5'd5;
    localparam logic [4:0] S_D_MY     = 5'd6;
    localparam logic [4:0] S_D_SQ     = 5'd7;
    localparam logic [4:0] S_RED_RD   = 5'd8;
    localparam logic [4:0] S_RED_EX   = 5'd9;
    localparam logic [4:0] S_STR_RD   = 5'd10;
    localparam logic [4:0] S_STR_EX   = 5'd11;
    localparam logic [4:0] S_COVER    = 5'd12;
    localparam logic [4:0] S_FND_RD   = 5'd13;
    localparam logic [4:0] S_FND_EX   = 5'd14;
    localparam logic [4:0] S_AUG      = 5'd15;
    localparam logic [4:0] S_MIN_RD   = 5'd16;
    localparam logic [4:0] S_MIN_EX   = 5'd17;
    localparam logic [4:0] S_ADJ_RD   = 5'd18;
    localparam logic [4:0] S_ADJ_EX   = 5'd19;
    localparam logic [4:0] S_EMIT     = 5'd20;
    localparam logic [4:0] S_EMIT_CHK = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;

    logic [4:0]            state_reg;
    logic [DIST_W-1:0]     max_dist_reg;
    logic [CW-1:0]         prev_cnt_reg;
    logic [CW-1:0]         cur_cnt_reg;
    logic [CW-1:0]         n_reg;
    logic [IW-1:0]         r_reg;
    logic [IW-1:0]         c_reg;
    logic                  red_col_reg;
    logic                  red_pass_reg;
    logic                  dist_emit_reg;
    logic [DW-1:0]         min_reg;
    logic                  min_found_reg;

    // Distance unit registers.
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [VW-1:0]         acc_reg;
    logic [VW-1:0]         v_reg;
    logic [DW-1:0]         sq_res_reg;
    logic [SW-1:0]         sq_i_reg;

    // Star, prime and cover bookkeeping. At most one star per row and per
    // column, and at most one prime per row.
    logic [MAX_POINTS-1:0] row_star_reg;
    logic [MAX_POINTS-1:0] col_star_reg;
    logic [MAX_POINTS-1:0] prime_v_reg;
    logic [MAX_POINTS-1:0] row_cov_reg;
    logic [MAX_POINTS-1:0] col_cov_reg;
    logic [IW-1:0]         star_col_reg     [MAX_POINTS];
    logic [IW-1:0]         col_star_row_reg [MAX_POINTS];
    logic [IW-1:0]         prime_col_reg    [MAX_POINTS];

    // Result register.
    logic                  out_valid_reg;
    logic [IDX_OUT_W-1:0]  out_cur_reg;
    logic [IDX_OUT_W-1:0]  out_prev_reg;
    logic                  out_hit_reg;
    logic                  out_last_reg;

    // Memory ports.
    logic                  prev_we;
    logic                  cur_we;
    logic [PW-1:0]         in_point;
    logic [PW-1:0]         prev_rdata;
    logic [PW-1:0]         cur_rdata;
    logic                  cost_we;
    logic [DW-1:0]         cost_wdata;
    logic [DW-1:0]         cost_rdata;

    // Sequencer helpers.
    logic                  in_acc;
    logic                  cfg_wr;
    logic [IW-1:0]         nm1;
    logic                  c_last;
    logic                  r_last;
    logic                  cell_last;
    logic                  inner_last;
    logic                  outer_last;
    logic                  uncov;
    logic                  is_zero;
    logic                  cell_real;
    logic [MAX_POINTS-1:0] n_mask;
    logic                  all_star;
    logic                  min_take;
    logic [CW-1:0]         n_solve;

    // Shared multiplier.
    logic [DW-1:0]         mul_a;
    logic [VW-1:0]         mul_p;
    logic [DW-1:0]         cand;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [CMP_W-1:0]      dist_ext;
    logic [CMP_W-1:0]      maxd_ext;
    logic [IW+IDX_OUT_W-1:0] r_wide;
    logic [IW+IDX_OUT_W-1:0] c_wide;

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    assign in_acc   = s_tvalid && s_tready;
    assign in_point = {s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS]};
    assign prev_we  = in_acc && (s_tuser == REQ_LOAD_PREV) && (prev_cnt_reg < CW'(MAX_POINTS));
    assign cur_we   = in_acc && (s_tuser == REQ_LOAD_CUR) && (cur_cnt_reg < CW'(MAX_POINTS));

    ptau_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (prev_we),
        .wr_addr (prev_cnt_reg[IW-1:0]),
        .wr_data (in_point),
        .rd_addr (c_reg),
        .rd_data (prev_rdata)
    );

    ptau_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_cur_ram (
        .clk     (clk),
        .wr_en   (cur_we),
        .wr_addr (cur_cnt_reg[IW-1:0]),
        .wr_data (in_point),
        .rd_addr (r_reg),
        .rd_data (cur_rdata)
    );

    // Cost matrix addressed as {row, column}; rows are current points.
    ptau_ram #(
        .WIDTH (DW),
        .DEPTH (CELLS)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (cost_we),
        .wr_addr ({r_reg, c_reg}),
        .wr_data (cost_wdata),
        .rd_addr ({r_reg, c_reg}),
        .rd_data (cost_rdata)
    );

    // ------------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------------
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DIST);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_DIST) ? {{(32-DIST_W){1'b0}}, max_dist_reg} : 32'd0;

    assign n_solve  = (cur_cnt_reg > prev_cnt_reg) ? cur_cnt_reg : prev_cnt_reg;
    assign nm1      = IW'(n_reg - CW'(1));
    assign c_last   = (c_reg == nm1);
    assign r_last   = (r_reg == nm1);
    assign cell_last  = c_last && r_last;
    assign inner_last = red_col_reg ? r_last : c_last;
    assign outer_last = red_col_reg ? c_last : r_last;
    assign uncov    = !row_cov_reg[r_reg] && !col_cov_reg[c_reg];
    assign is_zero  = (cost_rdata == '0);
    assign cell_real = ({1'b0, r_reg} < cur_cnt_reg) && ({1'b0, c_reg} < prev_cnt_reg);
    assign min_take = uncov && (!min_found_reg || (cost_rdata < min_reg));

    always_comb
    begin
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            n_mask[i] = (CW'(i) < n_reg);
        end
    end
    assign all_star = &(col_star_reg | ~n_mask);

    // Point coordinates: x in the upper half, y in the lower half.
    assign ax = cur_rdata[PW-1:COORD_BITS];
    assign ay = cur_rdata[COORD_BITS-1:0];
    assign bx = prev_rdata[PW-1:COORD_BITS];
    assign by = prev_rdata[COORD_BITS-1:0];

    // The one multiplier squares dx, then dy, then each square-root trial.
    assign cand = sq_res_reg | (DW'(1) << sq_i_reg);
    always_comb
    begin
        case (state_reg)
            S_D_MX:  mul_a = DW'(dx_reg);
            S_D_MY:  mul_a = DW'(dy_reg);
            default: mul_a = cand;
        endcase
    end
    assign mul_p = VW'(mul_a) * VW'(mul_a);

    assign dist_ext = CMP_W'(sq_res_reg);
    assign maxd_ext = CMP_W'(max_dist_reg);
    assign r_wide   = {{IDX_OUT_W{1'b0}}, r_reg};
    assign c_wide   = {{IDX_OUT_W{1'b0}}, c_reg};

    always_comb
    begin
        cost_we    = 1'b0;
        cost_wdata = cost_rdata;
        case (state_reg)
            S_BLD_WR:
            begin
                cost_we    = 1'b1;
                cost_wdata = cell_real ? sq_res_reg : '0;
            end
            S_RED_EX:
            begin
                cost_we    = red_pass_reg;
                cost_wdata = cost_rdata - min_reg;
            end
            S_ADJ_EX:
            begin
                cost_we = 1'b1;
                if (row_cov_reg[r_reg] && col_cov_reg[c_reg])
                begin
                    cost_wdata = cost_rdata + min_reg;
                end
                else if (!row_cov_reg[r_reg] && !col_cov_reg[c_reg])
                begin
                    cost_wdata = cost_rdata - min_reg;
                end
            end
            default:
            begin
                cost_we = 1'b0;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-2*IDX_OUT_W){1'b0}}, out_prev_reg, out_cur_reg};
    assign m_tuser  = out_hit_reg;
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_dist_reg  <= MAX_DIST_RST;
            prev_cnt_reg  <= '0;
            cur_cnt_reg   <= '0;
            n_reg         <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            red_col_reg   <= 1'b0;
            red_pass_reg  <= 1'b0;
            dist_emit_reg <= 1'b0;
            min_found_reg <= 1'b0;
            row_star_reg  <= '0;
            col_star_reg  <= '0;
            prime_v_reg   <= '0;
            row_cov_reg   <= '0;
            col_cov_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                max_dist_reg <= pwdata[DIST_W-1:0];
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (prev_we)
                    begin
                        prev_cnt_reg <= prev_cnt_reg + CW'(1);
                    end
                    if (cur_we)
                    begin
                        cur_cnt_reg <= cur_cnt_reg + CW'(1);
                    end
                    if (in_acc && (s_tuser == REQ_SOLVE))
                    begin
                        r_reg <= '0;
                        c_reg <= '0;
                        n_reg <= n_solve;
                        if (cur_cnt_reg == '0)
                        begin
                            // No current points: nothing to report, lists emptied.
                            prev_cnt_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= S_BLD_RD;
                        end
                    end
                end

                // Matrix build: padding cells are written as zero directly.
                S_BLD_RD:
                begin
                    dist_emit_reg <= 1'b0;
                    state_reg     <= cell_real ? S_D_RD : S_BLD_WR;
                end
                S_BLD_WR:
                begin
                    c_reg <= c_last ? '0 : c_reg + IW'(1);
                    if (c_last)
                    begin
                        r_reg <= r_reg + IW'(1);
                    end
                    if (cell_last)
                    begin
                        r_reg        <= '0;
                        red_col_reg  <= 1'b0;
                        red_pass_reg <= 1'b0;
                        state_reg    <= S_RED_RD;
                    end
                    else
                    begin
                        state_reg <= S_BLD_RD;
                    end
                end

                // Distance: squares on the shared multiplier, then a
                // one-bit-per-cycle integer square root.
                S_D_RD:
                begin
                    state_reg <= S_D_DIF;
                end
                S_D_DIF:
                begin
                    dx_reg    <= (ax > bx) ? ax - bx : bx - ax;
                    dy_reg    <= (ay > by) ? ay - by : by - ay;
                    state_reg <= S_D_MX;
                end
                S_D_MX:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_D_MY;
                end
                S_D_MY:
                begin
                    v_reg      <= (acc_reg + mul_p) << (2 * FRAC_BITS);
                    sq_res_reg <= '0;
                    sq_i_reg   <= SW'(DW - 1);
                    state_reg  <= S_D_SQ;
                end
                S_D_SQ:
                begin
                    if (mul_p <= v_reg)
                    begin
                        sq_res_reg <= cand;
                    end
                    if (sq_i_reg == '0)
                    begin
                        state_reg <= dist_emit_reg ? S_EMIT_CHK : S_BLD_WR;
                    end
                    else
                    begin
                        sq_i_reg <= sq_i_reg - SW'(1);
                    end
                end

                // Row then column reduction: a minimum pass, then a subtract
                // pass over the same line.
                S_RED_RD:
                begin
                    state_reg <= S_RED_EX;
                end
                S_RED_EX:
                begin
                    state_reg <= S_RED_RD;
                    if (!red_pass_reg)
                    begin
                        if (((red_col_reg ? r_reg : c_reg) == '0) || (cost_rdata < min_reg))
                        begin
                            min_reg <= cost_rdata;
                        end
                    end
                    if (!inner_last)
                    begin
                        if (red_col_reg)
                        begin
                            r_reg <= r_reg + IW'(1);
                        end
                        else
                        begin
                            c_reg <= c_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        red_pass_reg <= !red_pass_reg;
                        if (red_col_reg)
                        begin
                            r_reg <= '0;
                        end
                        else
                        begin
                            c_reg <= '0;
                        end
                        if (red_pass_reg)
                        begin
                            if (!outer_last)
                            begin
                                if (red_col_reg)
                                begin
                                    c_reg <= c_reg + IW'(1);
                                end
                                else
                                begin
                                    r_reg <= r_reg + IW'(1);
                                end
                            end
                            else if (!red_col_reg)
                            begin
                                red_col_reg <= 1'b1;
                                r_reg       <= '0;
                                c_reg       <= '0;
                            end
                            else
                            begin
                                r_reg        <= '0;
                                c_reg        <= '0;
                                row_star_reg <= '0;
                                col_star_reg <= '0;
                                row_cov_reg  <= '0;
                                col_cov_reg  <= '0;
                                state_reg    <= S_STR_RD;
                            end
                        end
                    end
                end

                // Greedy starring in row-major order.
                S_STR_RD:
                begin
                    state_reg <= S_STR_EX;
                end
                S_STR_EX:
                begin
                    if (is_zero && uncov)
                    begin
                        row_star_reg[r_reg]     <= 1'b1;
                        col_star_reg[c_reg]     <= 1'b1;
                        star_col_reg[r_reg]     <= c_reg;
                        col_star_row_reg[c_reg] <= r_reg;
                        row_cov_reg[r_reg]      <= 1'b1;
                        col_cov_reg[c_reg]      <= 1'b1;
                    end
                    c_reg <= c_last ? '0 : c_reg + IW'(1);
                    if (c_last)
                    begin
                        r_reg <= r_reg + IW'(1);
                    end
                    state_reg <= cell_last ? S_COVER : S_STR_RD;
                end

                // Cover the starred columns; done once every column has a star.
                S_COVER:
                begin
                    row_cov_reg <= '0;
                    col_cov_reg <= col_star_reg;
                    prime_v_reg <= '0;
                    r_reg       <= '0;
                    c_reg       <= '0;
                    state_reg   <= all_star ? S_EMIT : S_FND_RD;
                end

                // Search for the first uncovered zero in row-major order.
                S_FND_RD:
                begin
                    state_reg <= S_FND_EX;
                end
                S_FND_EX:
                begin
                    if (is_zero && uncov)
                    begin
                        prime_v_reg[r_reg]   <= 1'b1;
                        prime_col_reg[r_reg] <= c_reg;
                        if (row_star_reg[r_reg])
                        begin
                            row_cov_reg[r_reg]               <= 1'b1;
                            col_cov_reg[star_col_reg[r_reg]] <= 1'b0;
                            r_reg                            <= '0;
                            c_reg                            <= '0;
                            state_reg                        <= S_FND_RD;
                        end
                        else
                        begin
                            state_reg <= S_AUG;
                        end
                    end
                    else
                    begin
                        c_reg <= c_last ? '0 : c_reg + IW'(1);
                        if (c_last)
                        begin
                            r_reg <= r_reg + IW'(1);
                        end
                        if (cell_last)
                        begin
                            r_reg         <= '0;
                            min_found_reg <= 1'b0;
                            state_reg     <= S_MIN_RD;
                        end
                        else
                        begin
                            state_reg <= S_FND_RD;
                        end
                    end
                end

                // Augmenting path: star the zero at (r, c), unstar the star in
                // its column and follow that row's prime.
                S_AUG:
                begin
                    row_star_reg[r_reg]     <= 1'b1;
                    col_star_reg[c_reg]     <= 1'b1;
                    star_col_reg[r_reg]     <= c_reg;
                    col_star_row_reg[c_reg] <= r_reg;
                    if (col_star_reg[c_reg])
                    begin
                        row_star_reg[col_star_row_reg[c_reg]] <= 1'b0;
                        if (prime_v_reg[col_star_row_reg[c_reg]])
                        begin
                            r_reg <= col_star_row_reg[c_reg];
                            c_reg <= prime_col_reg[col_star_row_reg[c_reg]];
                        end
                        else
                        begin
                            state_reg <= S_COVER;
                        end
                    end
                    else
                    begin
                        state_reg <= S_COVER;
                    end
                end

                // Smallest uncovered value.
                S_MIN_RD:
                begin
                    state_reg <= S_MIN_EX;
                end
                S_MIN_EX:
                begin
                    if (min_take)
                    begin
                        min_reg       <= cost_rdata;
                        min_found_reg <= 1'b1;
                    end
                    c_reg <= c_last ? '0 : c_reg + IW'(1);
                    if (c_last)
                    begin
                        r_reg <= r_reg + IW'(1);
                    end
                    if (cell_last)
                    begin
                        r_reg     <= '0;
                        state_reg <= (min_found_reg || min_take) ? S_ADJ_RD : S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_MIN_RD;
                    end
                end

                // Add the minimum to doubly covered cells, take it from
                // uncovered ones, then search again.
                S_ADJ_RD:
                begin
                    state_reg <= S_ADJ_EX;
                end
                S_ADJ_EX:
                begin
                    c_reg <= c_last ? '0 : c_reg + IW'(1);
                    if (c_last)
                    begin
                        r_reg <= r_reg + IW'(1);
                    end
                    if (cell_last)
                    begin
                        r_reg     <= '0;
                        state_reg <= S_FND_RD;
                    end
                    else
                    begin
                        state_reg <= S_ADJ_RD;
                    end
                end

                // One result per current point; a real partner is checked
                // against the distance cut with a fresh distance.
                S_EMIT:
                begin
                    out_cur_reg  <= r_wide[IDX_OUT_W-1:0];
                    out_last_reg <= ({1'b0, r_reg} == cur_cnt_reg - CW'(1));
                    if (row_star_reg[r_reg] && ({1'b0, star_col_reg[r_reg]} < prev_cnt_reg))
                    begin
                        c_reg         <= star_col_reg[r_reg];
                        dist_emit_reg <= 1'b1;
                        state_reg     <= S_D_RD;
                    end
                    else
                    begin
                        out_prev_reg  <= '0;
                        out_hit_reg   <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_EMIT_CHK:
                begin
                    out_hit_reg   <= (dist_ext < maxd_ext);
                    out_prev_reg  <= (dist_ext < maxd_ext) ? c_wide[IDX_OUT_W-1:0] : '0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            prev_cnt_reg <= '0;
                            cur_cnt_reg  <= '0;
                            state_reg    <= S_IDLE;
                        end
                        else
                        begin
                            r_reg     <= r_reg + IW'(1);
                            state_reg <= S_EMIT;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/sv/point_track_assignment_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// point_track_assignment_unit_test: self-checking bench for the track linker
// Streams point loads and solve requests with random gaps and stalls, predicts
// the Munkres assignment of every solve and checks each emitted result item.
// ============================================================================
module point_track_assignment_unit_test;
    import ptau_pkg::*;

    localparam int NPTS = 32;

    // One expected result item.
    typedef struct packed {
        logic [4:0] cur_idx;
        logic [4:0] prev_idx;
        logic       matched;
        logic       last;
    } link_t;

    // Tracks the block's point lists and distance cut, solves each frame pair
    // with Munkres and keeps the links that the block still owes.
    class link_scoreboard;
        logic [23:0]     prev_pts[NPTS];
        logic [23:0]     cur_pts[NPTS];
        int              n_prev;
        int              n_cur;
        logic [16:0]     dist_cut;
        longint unsigned cost[NPTS][NPTS];
        byte             mark[NPTS][NPTS];
        bit [63:0]       rcov;
        bit [63:0]       ccov;
        link_t           pending[$];
        int              fails;

        function new();
            n_prev   = 0;
            n_cur    = 0;
            dist_cut = MAX_DIST_RST;
            fails    = 0;
        endfunction

        // Truncated root of the squared distance with four fraction bits.
        function longint unsigned pixel_dist(logic [23:0] a, logic [23:0] b);
            longint unsigned dx, dy, v, res, b2;
            dx  = (a[11:0] > b[11:0]) ? a[11:0] - b[11:0] : b[11:0] - a[11:0];
            dy  = (a[23:12] > b[23:12]) ? a[23:12] - b[23:12] : b[23:12] - a[23:12];
            v   = (dx * dx + dy * dy) << 8;
            res = 0;
            b2  = 64'd1 << 62;
            while (b2 > v) b2 = b2 >> 2;
            while (b2 != 0)
            begin
                if (v >= res + b2)
                begin
                    v   = v - (res + b2);
                    res = (res >> 1) + b2;
                end
                else
                    res = res >> 1;
                b2 = b2 >> 2;
            end
            return res;
        endfunction

        function int row_mark(int n, int r, byte m);
            for (int c = 0; c < n; c++) if (mark[r][c] == m) return c;
            return -1;
        endfunction

        function int col_mark(int n, int c, byte m);
            for (int r = 0; r < n; r++) if (mark[r][c] == m) return r;
            return -1;
        endfunction

        function void munkres(int n);
            longint unsigned m;
            int zr, zc, sc, sr, starred;
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    cost[r][c] = (r < n_cur && c < n_prev) ?
                                 pixel_dist(cur_pts[r], prev_pts[c]) : 0;
            for (int r = 0; r < n; r++)
            begin
                m = '1;
                for (int c = 0; c < n; c++) if (cost[r][c] < m) m = cost[r][c];
                for (int c = 0; c < n; c++) cost[r][c] -= m;
            end
            for (int c = 0; c < n; c++)
            begin
                m = '1;
                for (int r = 0; r < n; r++) if (cost[r][c] < m) m = cost[r][c];
                for (int r = 0; r < n; r++) cost[r][c] -= m;
            end
            for (int r = 0; r < NPTS; r++)
                for (int c = 0; c < NPTS; c++) mark[r][c] = 0;
            rcov = 0;
            ccov = 0;
            // Greedy starring in row-major order.
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    if (cost[r][c] == 0 && !rcov[r] && !ccov[c])
                    begin
                        mark[r][c] = 1;
                        rcov[r]    = 1;
                        ccov[c]    = 1;
                    end
            forever
            begin
                rcov    = 0;
                ccov    = 0;
                starred = 0;
                for (int r = 0; r < NPTS; r++)
                    for (int c = 0; c < NPTS; c++) if (mark[r][c] == 2) mark[r][c] = 0;
                for (int c = 0; c < n; c++)
                    if (col_mark(n, c, 1) >= 0)
                    begin
                        ccov[c] = 1;
                        starred++;
                    end
                if (starred >= n) return;
                forever
                begin
                    zr = -1;
                    zc = -1;
                    for (int r = 0; r < n && zr < 0; r++)
                    begin
                        if (rcov[r]) continue;
                        for (int c = 0; c < n; c++)
                            if (!ccov[c] && cost[r][c] == 0)
                            begin
                                zr = r;
                                zc = c;
                                break;
                            end
                    end
                    if (zr >= 0)
                    begin
                        mark[zr][zc] = 2;
                        sc = row_mark(n, zr, 1);
                        if (sc >= 0)
                        begin
                            rcov[zr] = 1;
                            ccov[sc] = 0;
                            continue;
                        end
                        // Augment along the alternating path of primes and stars.
                        forever
                        begin
                            sr = col_mark(n, zc, 1);
                            mark[zr][zc] = 1;
                            if (sr < 0) break;
                            mark[sr][zc] = 0;
                            zr = sr;
                            zc = row_mark(n, sr, 2);
                            if (zc < 0) break;
                        end
                        break;
                    end
                    else
                    begin
                        m = '1;
                        for (int r = 0; r < n; r++)
                            for (int c = 0; c < n; c++)
                                if (!rcov[r] && !ccov[c] && cost[r][c] < m) m = cost[r][c];
                        if (m == 64'hFFFF_FFFF_FFFF_FFFF) return;
                        for (int r = 0; r < n; r++)
                            for (int c = 0; c < n; c++)
                                if (rcov[r] && ccov[c]) cost[r][c] += m;
                                else if (!rcov[r] && !ccov[c]) cost[r][c] -= m;
                    end
                end
            end
        endfunction

        // Notes one accepted request and queues the links it produces.
        function void note_request(logic [1:0] req, logic [11:0] x, logic [11:0] y);
            int    n, j;
            link_t lk;
            if (req == REQ_LOAD_PREV)
            begin
                if (n_prev < NPTS) prev_pts[n_prev++] = {y, x};
            end
            else if (req == REQ_LOAD_CUR)
            begin
                if (n_cur < NPTS) cur_pts[n_cur++] = {y, x};
            end
            else if (req == REQ_SOLVE)
            begin
                n = (n_cur > n_prev) ? n_cur : n_prev;
                if (n > 0) munkres(n);
                for (int i = 0; i < n_cur; i++)
                begin
                    j = row_mark(n, i, 1);
                    lk.cur_idx = i[4:0];
                    lk.matched = (j >= 0 && j < n_prev &&
                                  pixel_dist(cur_pts[i], prev_pts[j]) < dist_cut);
                    lk.prev_idx = lk.matched ? j[4:0] : 5'd0;
                    lk.last     = (i + 1 == n_cur);
                    pending = {pending, lk};
                end
                n_prev = 0;
                n_cur  = 0;
            end
        endfunction

        // Compares one emitted result with the oldest pending link.
        function void check_link(link_t got);
            link_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result item %p", got);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.cur_idx != want.cur_idx)
            begin
                $error("current_index: expected %0d, got %0d", want.cur_idx, got.cur_idx);
                fails++;
            end
            if (got.prev_idx != want.prev_idx)
            begin
                $error("matched_prev: expected %0d, got %0d", want.prev_idx, got.prev_idx);
                fails++;
            end
            if (got.matched != want.matched)
            begin
                $error("is_matched: expected %0d, got %0d", want.matched, got.matched);
                fails++;
            end
            if (got.last != want.last)
            begin
                $error("last_result: expected %0d, got %0d", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;   // x_coord, y_coord
    logic [1:0]            s_tuser;   // req_type
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;   // current_index, matched_prev, zero fill
    logic                  m_tuser;   // is_matched
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    link_scoreboard links = new();
    int  items_sent;
    bit  burst_mode;   // while set, neither side inserts gaps

    point_track_assignment_unit uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous absolute limit, since large solves run long.
    initial
    begin
        #300ms;
        $display("[point_track_assignment_unit] ERROR");
        $finish;
    end

    // Mostly short gaps, now and then a long one, none during bursts.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: ready pulses of random length, now and then separated by stalls.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (gap_len() > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    // Result monitor: values are sampled as they stood before the edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            links.check_link({m_tdata[4:0], m_tdata[9:5], m_tuser, m_tlast});

    task automatic send_request(logic [1:0] req, logic [11:0] x, logic [11:0] y);
        int g;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {y, x};
        do @(posedge clk); while (!s_tready);
        links.note_request(req, x, y);
        items_sent++;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Waits until every owed result has come out, then lets the block settle.
    task automatic drain();
        if (s_tvalid)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (links.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cut(logic [16:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_MAX_DIST, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        links.dist_cut = value;
        @(posedge clk);
    endtask

    // One frame pair: loads in random interleaving, a little noise, a solve.
    // Current points mostly sit near a previous point so that links form.
    task automatic send_frame(int np, int nc, bit spread);
        logic [11:0] px[NPTS];
        logic [11:0] py[NPTS];
        int          ip, ic, k;
        for (int i = 0; i < NPTS; i++)
        begin
            px[i] = 12'($urandom_range(0, 4095));
            py[i] = 12'($urandom_range(0, 4095));
        end
        ip = 0;
        ic = 0;
        while (ip < np || ic < nc)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(2'd3, 12'($urandom), 12'($urandom));
            if (ip < np && (ic >= nc || $urandom_range(0, 1)))
            begin
                send_request(REQ_LOAD_PREV, px[ip], py[ip]);
                ip++;
            end
            else
            begin
                k = (np > 0) ? $urandom_range(0, np - 1) : 0;
                if (spread || np == 0)
                    send_request(REQ_LOAD_CUR, 12'($urandom), 12'($urandom));
                else
                    send_request(REQ_LOAD_CUR, px[k] + 12'($urandom_range(0, 80)) - 12'd40,
                                 py[k] + 12'($urandom_range(0, 80)) - 12'd40);
                ic++;
            end
        end
        send_request(REQ_SOLVE, 12'($urandom), 12'($urandom));
    endtask

    initial
    begin
        int np, nc;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rst_n      = 1'b0;
        items_sent = 0;
        burst_mode = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coordinate extremes at the reset distance cut.
        send_request(REQ_LOAD_PREV, 12'd0, 12'd0);
        send_request(REQ_LOAD_PREV, 12'hFFF, 12'hFFF);
        send_request(REQ_LOAD_CUR, 12'hFFF, 12'hFFF);
        send_request(REQ_LOAD_CUR, 12'd0, 12'd0);
        send_request(2'd3, 12'hFFF, 12'hFFF);
        send_request(REQ_SOLVE, 12'd0, 12'd0);
        // Empty current list: no results, both lists still cleared.
        send_request(REQ_LOAD_PREV, 12'd5, 12'd5);
        send_request(REQ_SOLVE, 12'hFFF, 12'hFFF);
        // More current than previous points: the extra ones take padding partners.
        send_request(REQ_LOAD_PREV, 12'd100, 12'd100);
        send_request(REQ_LOAD_CUR, 12'd4000, 12'd10);
        send_request(REQ_LOAD_CUR, 12'd101, 12'd102);
        send_request(REQ_LOAD_CUR, 12'd10, 12'd4000);
        send_request(REQ_SOLVE, 12'd0, 12'd0);

        // Zero cut: nothing can match, even coincident points.
        write_cut(17'd0);
        send_request(REQ_LOAD_PREV, 12'd7, 12'd9);
        send_request(REQ_LOAD_CUR, 12'd7, 12'd9);
        send_request(REQ_SOLVE, 12'd0, 12'd0);

        // Widest cut: opposite corners still match.
        write_cut(17'd92672);
        send_request(REQ_LOAD_PREV, 12'd0, 12'hFFF);
        send_request(REQ_LOAD_CUR, 12'hFFF, 12'd0);
        send_request(REQ_SOLVE, 12'd0, 12'd0);

        // Full lists, mostly coincident points; the 33rd load of each list drops.
        burst_mode = 1'b1;
        for (int i = 0; i <= NPTS; i++)
            send_request(REQ_LOAD_PREV, 12'(i * 120), 12'(4095 - i * 120));
        for (int i = NPTS; i >= 0; i--)
            send_request(REQ_LOAD_CUR, 12'(i * 120), 12'(4095 - i * 120));
        send_request(REQ_SOLVE, 12'd0, 12'd0);
        burst_mode = 1'b0;
        write_cut(MAX_DIST_RST);

        // Random frames with occasional cut changes and bursts.
        while (items_sent < 250)
        begin
            burst_mode = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0:       write_cut(17'($urandom_range(0, 92672)));
                1:       write_cut(17'($urandom_range(0, 3) == 0 ? 0 : 92672));
                2:       write_cut(17'($urandom_range(200, 1200)));
                default: ;
            endcase
            if ($urandom_range(0, 60) == 0)
            begin
                np = $urandom_range(24, NPTS);
                nc = $urandom_range(24, NPTS);
            end
            else
            begin
                np = $urandom_range(0, 6);
                nc = $urandom_range(0, 6);
            end
            send_frame(np, nc, $urandom_range(0, 3) == 0);
        end

        burst_mode = 1'b0;
        drain();
        if (links.fails == 0)
            $display("[point_track_assignment_unit] OK");
        else
            $display("[point_track_assignment_unit] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ptau_pkg.sv
rtl/core/ptau_ram.sv
rtl/core/point_track_assignment_unit.sv
tb/sv/point_track_assignment_unit_test.sv
